>>> rtl/core/assert_macros.svh
// Assertion macros for the stack block.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/lss_pkg.sv
// Shared types and constants of the searchable stack.
// No dependencies.
package lss_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int MODE_W    = 2;
	localparam int WORD_W    = 32;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 7;

	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	// Per-cycle commands broadcast to every cell.
	typedef struct packed {
		logic push;  // shift words towards the bottom, new word into cell 0
		logic pop;   // shift words towards the top
		logic load;  // capture compare result into the hit flag
		logic scan;  // shift hit flags one cell towards the bottom
	} cell_ctl_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] popped_value;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         count;
		logic                     is_empty;
	} result_t;

endpackage

>>> rtl/core/lss_if.sv
// Request and result channel interfaces of the searchable stack.
// Depends on lss_pkg.
interface lss_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [lss_pkg::MODE_W-1:0]        mode;
	logic signed [lss_pkg::WORD_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface lss_res_if;
	logic                              valid;
	logic                              ready;
	logic [lss_pkg::STAT_W-1:0]        status;
	logic signed [lss_pkg::WORD_W-1:0] popped_value;
	logic [lss_pkg::POS_W-1:0]         position;
	logic [lss_pkg::POS_W-1:0]         count;
	logic                              is_empty;

	modport source (output valid, output status, output popped_value, output position,
		output count, output is_empty, input ready);
	modport sink (input valid, input status, input popped_value, input position,
		input count, input is_empty, output ready);
endinterface

>>> rtl/core/lss_cell.sv
// One stack cell: a stored word, its match flag and the neighbour shifts.
// Depends on lss_pkg.
module lss_cell #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lss_pkg::cell_ctl_t                ctl,
	input  logic [$clog2(DEPTH+1)-1:0]        count,
	input  logic signed [lss_pkg::WORD_W-1:0] key,
	input  logic signed [lss_pkg::WORD_W-1:0] left_data,
	input  logic signed [lss_pkg::WORD_W-1:0] right_data,
	input  logic                              left_hit,
	output logic signed [lss_pkg::WORD_W-1:0] data,
	output logic                              hit
);
	localparam int CW = $clog2(DEPTH+1);

	logic signed [lss_pkg::WORD_W-1:0] data_q;
	logic                              hit_q;
	logic                              held;

	// cells at or beyond the fill count hold stale words
	assign held = CW'(IDX) < count;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= left_data;
		end else if (ctl.pop) begin
			data_q <= right_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.load) begin
			hit_q <= held && (data_q == key);
		end else if (ctl.scan) begin
			hit_q <= left_hit;
		end
	end

	assign data = data_q;
	assign hit  = hit_q;
endmodule

>>> rtl/core/lifo_stack_with_search.sv
// Searchable LIFO stack: a row of DEPTH cells with newest word in cell 0, plus control.
// Depends on lss_pkg, lss_if, lss_cell and assert_macros.svh.
//
// Push, pop and the unused mode take one request per cycle while the result register is empty
// or can pass its result on; each result goes through a result register, then an output register. A
// search loads every cell's match flag together, then shifts the flags one cell a cycle towards
// the last cell (DEPTH-1), where the oldest held entries arrive first; it holds the request
// channel until a flag reaches the last cell or the step counter reaches DEPTH-1.
// A push onto a full stack and a pop of an empty one leave the stack as it was. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module lifo_stack_with_search #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	lss_cmd_if.sink cmd,
	lss_res_if.source res
);
	localparam int CW = $clog2(DEPTH+1);
	localparam int TW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [TW-1:0] T_LAST  = TW'(DEPTH-1);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [TW-1:0]      t_q;
	logic               res_valid_q;
	lss_pkg::result_t   res_q;
	logic               out_valid_q;
	lss_pkg::result_t   out_q;

	lss_pkg::cell_ctl_t ctl;
	lss_pkg::result_t   imm_res;
	lss_pkg::result_t   scan_res;
	logic               acc;
	logic               out_free;
	logic               full;
	logic               empty;
	logic               top_hit;
	logic               scan_done;
	logic [CW-1:0]      count_nxt;

	logic signed [lss_pkg::WORD_W-1:0] data_w [DEPTH];
	logic                              hit_w  [DEPTH];

	assign out_free  = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && (!res_valid_q || out_free);
	assign acc       = cmd.valid && cmd.ready;
	assign full      = count_q == DEPTH_C;
	assign empty     = count_q == '0;
	assign top_hit   = hit_w[DEPTH-1];
	assign scan_done = (state_q == ST_SCAN) && (top_hit || t_q == T_LAST);

	always_comb begin
		ctl       = '0;
		count_nxt = count_q;
		imm_res   = '0;
		unique case (cmd.mode)
			lss_pkg::MODE_PUSH: begin
				if (full) begin
					imm_res.status = lss_pkg::STAT_PUSH_FULL;
				end else begin
					ctl.push  = acc;
					count_nxt = count_q + CW'(1);
				end
			end
			lss_pkg::MODE_POP: begin
				if (empty) begin
					imm_res.status = lss_pkg::STAT_POP_EMPTY;
				end else begin
					ctl.pop              = acc;
					count_nxt            = count_q - CW'(1);
					imm_res.popped_value = data_w[0];
				end
			end
			lss_pkg::MODE_SEARCH: begin
				ctl.load = acc;
			end
			default: begin
			end
		endcase
		imm_res.count    = lss_pkg::POS_W'(count_nxt);
		imm_res.is_empty = count_nxt == '0;
		ctl.scan         = (state_q == ST_SCAN) && !scan_done;

		scan_res          = '0;
		scan_res.count    = lss_pkg::POS_W'(count_q);
		scan_res.is_empty = empty;
		if (top_hit) begin
			scan_res.status   = lss_pkg::STAT_OK;
			// matched cell index is DEPTH-1-t, position counts from the oldest
			scan_res.position = lss_pkg::POS_W'(count_q + CW'(t_q) + CW'(1) - DEPTH_C);
		end else begin
			scan_res.status = lss_pkg::STAT_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			t_q         <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid_q && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && cmd.mode != lss_pkg::MODE_SEARCH) begin
						res_q       <= imm_res;
						res_valid_q <= 1'b1;
					end else if (out_free) begin
						res_valid_q <= 1'b0;
					end
					if (acc) begin
						count_q <= count_nxt;
						if (cmd.mode == lss_pkg::MODE_SEARCH) begin
							state_q <= ST_SCAN;
							t_q     <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						res_q       <= scan_res;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						t_q <= t_q + TW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [lss_pkg::WORD_W-1:0] left_d;
		logic signed [lss_pkg::WORD_W-1:0] right_d;
		logic                              left_h;
		if (i == 0) begin : g_first
			assign left_d = cmd.value;
			assign left_h = 1'b0;
		end else begin : g_inner
			assign left_d = data_w[i-1];
			assign left_h = hit_w[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_d = data_w[i];
		end else begin : g_mid
			assign right_d = data_w[i+1];
		end
		lss_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.key       (cmd.value),
			.left_data (left_d),
			.right_data(right_d),
			.left_hit  (left_h),
			.data      (data_w[i]),
			.hit       (hit_w[i])
		);
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_q.status;
	assign res.popped_value = out_q.popped_value;
	assign res.position     = out_q.position;
	assign res.count        = out_q.count;
	assign res.is_empty     = out_q.is_empty;

	`ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_C)
	`ASSERT_IMPL(a_scan_no_pending, state_q == ST_SCAN, !res_valid_q)
	`ASSERT_NEXT(a_push_grows, ctl.push, count_q == $past(count_q) + CW'(1))
	`ASSERT_NEXT(a_pop_shrinks, ctl.pop, count_q == $past(count_q) - CW'(1))
endmodule

>>> tb/lifo_stack_with_search_test.sv
`timescale 1ns / 1ps
// Testbench for lifo_stack_with_search: push, pop, search and unused-mode requests with random idling,
// each result checked against a stack kept inside the bench.
// Depends on lss_pkg, lss_if and the lifo_stack_with_search RTL.
module lifo_stack_with_search_test;

	localparam int DEPTH = lss_pkg::DEPTH_DEF;
	// unused code, no operation
	localparam logic [lss_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
	localparam logic signed [lss_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [lss_pkg::WORD_W-1:0] WORD_MIN = 32'sh80000000;
	localparam int LONG_HOLD = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [lss_pkg::MODE_W-1:0]        mode;
		logic signed [lss_pkg::WORD_W-1:0] value;
	} req_t;

	logic clk;
	logic arst_n;

	lss_cmd_if cmd_if();
	lss_res_if res_if();

	lifo_stack_with_search #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	req_t req_q[$];
	lss_pkg::result_t due_results[$];
	// contents as the requests are queued
	logic signed [lss_pkg::WORD_W-1:0] planned_words[$];
	logic signed [lss_pkg::WORD_W-1:0] stack_words[DEPTH];
	int stack_fill = 0;
	int err_count = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 62;
	bit req_done = 1'b0;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("lifo_stack_with_search_test: done, errors");
		$finish;
	end

	function automatic lss_pkg::result_t apply_to_stack(req_t r);
		lss_pkg::result_t o;
		o = '0;
		case (r.mode)
		lss_pkg::MODE_PUSH: begin
			if (stack_fill >= DEPTH) begin
				o.status = lss_pkg::STAT_PUSH_FULL;
			end else begin
				stack_words[stack_fill] = r.value;
				stack_fill++;
			end
		end
		lss_pkg::MODE_POP: begin
			if (stack_fill == 0) begin
				o.status = lss_pkg::STAT_POP_EMPTY;
			end else begin
				stack_fill--;
				o.popped_value = stack_words[stack_fill];
			end
		end
		lss_pkg::MODE_SEARCH: begin
			o.status = lss_pkg::STAT_NOT_FOUND;
			// oldest entry wins
			for (int i = 0; i < stack_fill; i++) begin
				if (stack_words[i] == r.value) begin
					o.status = lss_pkg::STAT_OK;
					o.position = lss_pkg::POS_W'(i + 1);
					break;
				end
			end
		end
		default: ;
		endcase
		o.count = lss_pkg::POS_W'(stack_fill);
		o.is_empty = (stack_fill == 0);
		return o;
	endfunction

	function automatic logic signed [lss_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
		0, 1, 2, 3: return $signed($urandom_range(15)) - 8;
		4: begin
			case ($urandom_range(3))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			default: return -1;
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	task automatic add_req(logic [lss_pkg::MODE_W-1:0] mode,
			logic signed [lss_pkg::WORD_W-1:0] value);
		req_t r;
		r.mode = mode;
		r.value = value;
		req_q.push_back(r);
		if (mode == lss_pkg::MODE_PUSH && planned_words.size() < DEPTH)
			planned_words.push_back(value);
		else if (mode == lss_pkg::MODE_POP && planned_words.size() > 0)
			void'(planned_words.pop_back());
	endtask

	task automatic plan_one(int push_pct, int pop_pct);
		int r;
		logic signed [lss_pkg::WORD_W-1:0] w;
		r = $urandom_range(99);
		if (r < push_pct) begin
			add_req(lss_pkg::MODE_PUSH, pick_word());
		end else if (r < push_pct + pop_pct) begin
			add_req(lss_pkg::MODE_POP, pick_word());
		end else if (r < 97) begin
			if (planned_words.size() > 0 && $urandom_range(99) < 65)
				w = planned_words[$urandom_range(planned_words.size() - 1)];
			else
				w = pick_word();
			add_req(lss_pkg::MODE_SEARCH, w);
		end else begin
			add_req(MODE_NONE, pick_word());
		end
	endtask

	// Runs that fill to the top, drain to the bottom, or wander in between.
	task automatic plan_random(int total);
		int done;
		int run_len;
		int kind;
		int push_pct;
		int pop_pct;
		done = 0;
		kind = 0;
		while (done < total) begin
			case (kind)
			0: begin
				push_pct = 85;
				pop_pct = 5;
				run_len = $urandom_range(120, 80);
			end
			1: begin
				push_pct = 5;
				pop_pct = 85;
				run_len = $urandom_range(120, 80);
			end
			default: begin
				push_pct = 40;
				pop_pct = 30;
				run_len = $urandom_range(90, 20);
			end
			endcase
			for (int k = 0; k < run_len && done < total; k++) begin
				plan_one(push_pct, pop_pct);
				done++;
			end
			kind = $urandom_range(2);
		end
	endtask

	task automatic wait_drained();
		while (req_q.size() != 0 || cmd_if.valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		add_req(lss_pkg::MODE_PUSH, WORD_MAX);
		add_req(lss_pkg::MODE_PUSH, WORD_MIN);
		add_req(lss_pkg::MODE_PUSH, '0);
		add_req(lss_pkg::MODE_PUSH, -1);
		add_req(lss_pkg::MODE_PUSH, -1);
		add_req(lss_pkg::MODE_SEARCH, -1);
		add_req(lss_pkg::MODE_SEARCH, WORD_MIN);
		add_req(lss_pkg::MODE_SEARCH, WORD_MAX);
		add_req(lss_pkg::MODE_SEARCH, 32'sd12345);
		add_req(MODE_NONE, -1);
		repeat (5) add_req(lss_pkg::MODE_POP, '0);
		add_req(lss_pkg::MODE_POP, -1);
		add_req(lss_pkg::MODE_SEARCH, '0);
		add_req(MODE_NONE, '0);
		wait_drained();

		plan_random(300);
		wait_drained();

		send_idle_pct = 62;
		recv_idle_pct = 16;
		hold_go = 1'b1;
		plan_random(300);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		plan_random(330);
		wait_drained();

		repeat (DEPTH + 8) @(posedge clk);
		if (err_count == 0 && due_results.size() == 0) begin
			$display("lifo_stack_with_search_test: done, clean");
		end else begin
			$display("lifo_stack_with_search_test: done, errors");
		end
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.mode <= lss_pkg::MODE_PUSH;
			cmd_if.value <= '0;
		end else if (!cmd_if.valid || req_done) begin
			if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_if.valid <= 1'b1;
				cmd_if.mode <= req_q[0].mode;
				cmd_if.value <= req_q[0].value;
				void'(req_q.pop_front());
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		req_t got_req;
		lss_pkg::result_t want;
		req_done = 1'b0;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				req_done = 1'b1;
				got_req.mode = cmd_if.mode;
				got_req.value = cmd_if.value;
				due_results.push_back(apply_to_stack(got_req));
			end
			if (res_if.valid && res_if.ready) begin
				if (due_results.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: result with no request outstanding", $realtime);
				end else begin
					want = due_results.pop_front();
					if (res_if.status !== want.status
							|| res_if.popped_value !== want.popped_value
							|| res_if.position !== want.position
							|| res_if.count !== want.count
							|| res_if.is_empty !== want.is_empty) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: expected st %0d pop %0d pos %0d cnt %0d emp %0b,",
								$realtime, want.status, want.popped_value, want.position,
								want.count, want.is_empty,
								" got st %0d pop %0d pos %0d cnt %0d emp %0b",
								res_if.status, res_if.popped_value, res_if.position,
								res_if.count, res_if.is_empty);
					end
				end
			end
		end
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lss_pkg.sv
rtl/core/lss_if.sv
rtl/core/lss_cell.sv
rtl/core/lifo_stack_with_search.sv
tb/lifo_stack_with_search_test.sv
